@@ src/round_robin_task_scheduler_core_macros.svh @@
// Assertion macros for the round-robin task scheduler core.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define RRTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scheduler assertion failed");
`define RRTS_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("scheduler forbidden condition seen");
`else
`define RRTS_ASSERT(label, clk, rst_n, prop)
`define RRTS_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

@@ src/rrts_pkg.sv @@
// Shared constants, codes and structures of the round-robin task scheduler.
// No dependencies; used by every module of the block.
package rrts_pkg;

  localparam int MaxTasks   = 8;
  localparam int FrameBytes = 64;
  localparam int SlotIdxW   = $clog2(MaxTasks);
  localparam int SlotW      = $clog2(MaxTasks + 1);
  localparam int SumW       = SlotW + 1;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpYield = 2'd1,
    OpExit  = 2'd2,
    OpQuery = 2'd3
  } rrts_op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StFull      = 3'd1,
    StNoReady   = 3'd2,
    StOverflow  = 3'd3,
    StNoCurrent = 3'd4
  } rrts_status_e;

  typedef logic [3:0] rrts_nslot_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] sp;
    logic [31:0] top;
    logic [31:0] size;
  } rrts_entry_t;

  typedef struct packed {
    rrts_status_e status;
    logic [15:0]  task_id;
    logic         is_running;
    logic [31:0]  next_sp;
    rrts_nslot_t  next_slot;
    logic         freed_valid;
    logic [31:0]  freed_base;
  } rrts_result_t;

  typedef struct packed {
    logic             push;
    logic [SlotW-1:0] push_slot;
    logic             pop;
  } rrts_q_cmd_t;

  typedef struct packed {
    logic             empty;
    logic [SlotW-1:0] count;
    logic [SlotW-1:0] rd_slot;
  } rrts_q_stat_t;

endpackage

@@ src/round_robin_task_scheduler_core.sv @@
// Channel | Direction | Handshake                 | Payload
// request | in        | in_valid_i / in_ready_o   | opcode, stack_top, stack_bytes, saved_sp,
//         |           |                           | query_pid
// result  | out       | out_valid_o / out_ready_i | status, task_id, is_running, next_sp,
//         |           |                           | next_slot, freed_valid, freed_base
// One request is worked on at a time. An add claims the first free slot; yield and exit
// save the current task's stack pointer, then pop the ready queue and read the next entry.
// A query of a nonzero id walks the slot table one entry a cycle through its read port.
// The result sits in an output register, so the next request is taken while it waits.
// A stalled output holds the finished request in its last state until the register frees.
// Reset is asynchronous and needs no clearing pass; running flags reset in flip-flops.
`include "round_robin_task_scheduler_core_macros.svh"
module round_robin_task_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] stack_top_i,
  input  logic [31:0] stack_bytes_i,
  input  logic [31:0] saved_sp_i,
  input  logic [15:0] query_pid_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] task_id_o,
  output logic        is_running_o,
  output logic [31:0] next_sp_o,
  output logic [3:0]  next_slot_o,
  output logic        freed_valid_o,
  output logic [31:0] freed_base_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_RD_CUR, S_WR_CUR, S_POP, S_POP_WAIT, S_SLOT_WAIT, S_QUERY, S_DONE
  } state_e;

  state_e                         state_q, state_d;
  rrts_pkg::rrts_op_e             op_q, op_d;
  logic [31:0]                    top_q, top_d;
  logic [31:0]                    size_q, size_d;
  logic [31:0]                    sp_q, sp_d;
  logic [15:0]                    qpid_q, qpid_d;
  logic [rrts_pkg::SlotW-1:0]     cur_q, cur_d;
  logic [rrts_pkg::MaxTasks-1:0]  running_q, running_d;
  logic [15:0]                    id_q, id_d;
  rrts_pkg::rrts_result_t         res_q, res_d;
  rrts_pkg::rrts_result_t         out_q, out_d;
  logic                           out_vld_q, out_vld_d;
  logic [rrts_pkg::SlotW-1:0]     qidx_q, qidx_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [rrts_pkg::SlotIdxW-1:0]  cmp_idx_q, cmp_idx_d;

  logic                           ram_we;
  logic [rrts_pkg::SlotIdxW-1:0]  ram_waddr;
  rrts_pkg::rrts_entry_t          ram_wdata;
  logic                           ram_re;
  logic [rrts_pkg::SlotIdxW-1:0]  ram_raddr;
  rrts_pkg::rrts_entry_t          ram_rdata;
  rrts_pkg::rrts_q_cmd_t          q_cmd;
  rrts_pkg::rrts_q_stat_t         q_stat;

  logic [rrts_pkg::SlotW-1:0]     cur_m1;
  logic [rrts_pkg::SlotIdxW-1:0]  cur_idx;
  logic [rrts_pkg::SlotW-1:0]     pop_m1;
  logic [rrts_pkg::SlotIdxW-1:0]  pop_idx;
  logic                           pop_in_range;
  logic                           free_found;
  logic [rrts_pkg::SlotIdxW-1:0]  free_idx;

  assign cur_m1       = cur_q - rrts_pkg::SlotW'(1);
  assign cur_idx      = cur_m1[rrts_pkg::SlotIdxW-1:0];
  assign pop_m1       = q_stat.rd_slot - rrts_pkg::SlotW'(1);
  assign pop_idx      = pop_m1[rrts_pkg::SlotIdxW-1:0];
  assign pop_in_range = (q_stat.rd_slot != '0) &&
                        (q_stat.rd_slot <= rrts_pkg::SlotW'(rrts_pkg::MaxTasks));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < rrts_pkg::MaxTasks; i++) begin
      if (!free_found && !running_q[i]) begin
        free_found = 1'b1;
        free_idx   = rrts_pkg::SlotIdxW'(i);
      end
    end
  end

  rrts_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rrts_ready_queue u_ready_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    top_d     = top_q;
    size_d    = size_q;
    sp_d      = sp_q;
    qpid_d    = qpid_q;
    cur_d     = cur_q;
    running_d = running_q;
    id_d      = id_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    qidx_d    = qidx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur_idx;
    q_cmd     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = rrts_pkg::rrts_op_e'(opcode_i);
          top_d  = stack_top_i;
          size_d = stack_bytes_i;
          sp_d   = saved_sp_i;
          qpid_d = query_pid_i;
          res_d  = '0;
          res_d.status = rrts_pkg::StOk;
          qidx_d = '0;
          case (rrts_pkg::rrts_op_e'(opcode_i))
            rrts_pkg::OpAdd:   state_d = S_ADD;
            rrts_pkg::OpYield: state_d = (cur_q != '0) ? S_RD_CUR : S_POP;
            rrts_pkg::OpExit: begin
              if (cur_q != '0) begin
                state_d = S_RD_CUR;
              end else begin
                res_d.status = rrts_pkg::StNoCurrent;
                state_d      = S_DONE;
              end
            end
            rrts_pkg::OpQuery: state_d = (query_pid_i != '0) ? S_QUERY : S_DONE;
            default:           state_d = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        if (!free_found) begin
          res_d.status = rrts_pkg::StFull;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = free_idx;
          ram_wdata.id    = id_q;
          ram_wdata.sp    = top_q - 32'(rrts_pkg::FrameBytes);
          ram_wdata.top   = top_q;
          ram_wdata.size  = size_q;
          running_d[free_idx] = 1'b1;
          q_cmd.push      = 1'b1;
          q_cmd.push_slot = rrts_pkg::SlotW'(free_idx) + rrts_pkg::SlotW'(1);
          res_d.task_id   = id_q;
          id_d            = id_q + 16'd1;
        end
        state_d = S_DONE;
      end
      S_RD_CUR: begin
        ram_re  = 1'b1;
        state_d = S_WR_CUR;
      end
      S_WR_CUR: begin
        ram_we       = 1'b1;
        ram_wdata.sp = sp_q;
        if (op_q == rrts_pkg::OpExit) begin
          res_d.freed_valid  = 1'b1;
          res_d.freed_base   = ram_rdata.top - ram_rdata.size;
          running_d[cur_idx] = 1'b0;
        end else begin
          q_cmd.push      = 1'b1;
          q_cmd.push_slot = cur_q;
        end
        state_d = S_POP;
      end
      S_POP: begin
        if (q_stat.empty) begin
          cur_d         = '0;
          res_d.status  = rrts_pkg::StNoReady;
          res_d.next_sp = '0;
          state_d       = S_DONE;
        end else begin
          q_cmd.pop = 1'b1;
          state_d   = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        if (pop_in_range) begin
          cur_d     = q_stat.rd_slot;
          ram_re    = 1'b1;
          ram_raddr = pop_idx;
          state_d   = S_SLOT_WAIT;
        end else begin
          cur_d        = '0;
          res_d.status = rrts_pkg::StNoReady;
          state_d      = S_DONE;
        end
      end
      S_SLOT_WAIT: begin
        res_d.next_sp = ram_rdata.sp;
        res_d.status  = (ram_rdata.sp < (ram_rdata.top - ram_rdata.size)) ?
                        rrts_pkg::StOverflow : rrts_pkg::StOk;
        state_d = S_DONE;
      end
      S_QUERY: begin
        if (qidx_q != rrts_pkg::SlotW'(rrts_pkg::MaxTasks)) begin
          ram_re    = 1'b1;
          ram_raddr = qidx_q[rrts_pkg::SlotIdxW-1:0];
          qidx_d    = qidx_q + rrts_pkg::SlotW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = qidx_q[rrts_pkg::SlotIdxW-1:0];
        end else if (!cmp_vld_q) begin
          state_d = S_DONE;
        end
        if (cmp_vld_q && running_q[cmp_idx_q] && (ram_rdata.id == qpid_q)) begin
          res_d.is_running = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d           = res_q;
          out_d.next_slot = rrts_pkg::rrts_nslot_t'(cur_q);
          out_vld_d       = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= rrts_pkg::OpAdd;
      top_q     <= '0;
      size_q    <= '0;
      sp_q      <= '0;
      qpid_q    <= '0;
      cur_q     <= '0;
      running_q <= '0;
      id_q      <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
      qidx_q    <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      top_q     <= top_d;
      size_q    <= size_d;
      sp_q      <= sp_d;
      qpid_q    <= qpid_d;
      cur_q     <= cur_d;
      running_q <= running_d;
      id_q      <= id_d;
      res_q     <= res_d;
      out_q     <= out_d;
      out_vld_q <= out_vld_d;
      qidx_q    <= qidx_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign task_id_o     = out_q.task_id;
  assign is_running_o  = out_q.is_running;
  assign next_sp_o     = out_q.next_sp;
  assign next_slot_o   = out_q.next_slot;
  assign freed_valid_o = out_q.freed_valid;
  assign freed_base_o  = out_q.freed_base;

  `RRTS_ASSERT(a_cur_in_range, clk_i, rst_ni, cur_q <= rrts_pkg::SlotW'(rrts_pkg::MaxTasks))
  `RRTS_ASSERT(a_cur_running, clk_i, rst_ni, (state_q == S_IDLE && cur_q != '0) |-> running_q[cur_idx])
  `RRTS_ASSERT(a_queue_bound, clk_i, rst_ni, (state_q == S_IDLE) |-> (int'(q_stat.count) + int'(cur_q != '0) <= $countones(running_q)))
  `RRTS_ASSERT_NEVER(a_no_drop, clk_i, rst_ni, out_vld_q && !out_ready_i && state_q == S_DONE && state_d == S_IDLE)

endmodule

@@ src/rrts_slot_ram.sv @@
// Slot table memory: one write port and one read port with registered data.
// Depends on rrts_pkg for the entry layout and the table depth.
module rrts_slot_ram (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [rrts_pkg::SlotIdxW-1:0]  waddr_i,
  input  rrts_pkg::rrts_entry_t          wdata_i,
  input  logic                           re_i,
  input  logic [rrts_pkg::SlotIdxW-1:0]  raddr_i,
  output rrts_pkg::rrts_entry_t          rdata_o
);

  rrts_pkg::rrts_entry_t mem [rrts_pkg::MaxTasks];
  rrts_pkg::rrts_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rrts_ready_queue.sv @@
// Ready queue of slot numbers held in a small memory with head and fill count.
// Depends on rrts_pkg; a popped slot number is registered before it shows on rd_slot.
module rrts_ready_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rrts_pkg::rrts_q_cmd_t  cmd_i,
  output rrts_pkg::rrts_q_stat_t stat_o
);

  logic [rrts_pkg::SlotW-1:0]    mem [rrts_pkg::MaxTasks];
  logic [rrts_pkg::SlotIdxW-1:0] head_q, head_d;
  logic [rrts_pkg::SlotW-1:0]    count_q, count_d;
  logic [rrts_pkg::SlotW-1:0]    rd_q;
  logic [rrts_pkg::SumW-1:0]     sum;
  logic [rrts_pkg::SumW-1:0]     tail_full;
  logic [rrts_pkg::SlotIdxW-1:0] tail;
  logic                          full;
  logic                          empty;
  logic                          push_ok;
  logic                          pop_ok;

  assign full    = (count_q == rrts_pkg::SlotW'(rrts_pkg::MaxTasks));
  assign empty   = (count_q == '0);
  assign push_ok = cmd_i.push && !full;
  assign pop_ok  = cmd_i.pop && !empty;

  assign sum       = rrts_pkg::SumW'(head_q) + rrts_pkg::SumW'(count_q);
  assign tail_full = (sum >= rrts_pkg::SumW'(rrts_pkg::MaxTasks)) ?
                     sum - rrts_pkg::SumW'(rrts_pkg::MaxTasks) : sum;
  assign tail      = tail_full[rrts_pkg::SlotIdxW-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (pop_ok) begin
      head_d = (head_q == rrts_pkg::SlotIdxW'(rrts_pkg::MaxTasks - 1)) ?
               '0 : head_q + rrts_pkg::SlotIdxW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + rrts_pkg::SlotW'(1);
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - rrts_pkg::SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail] <= cmd_i.push_slot;
    end
    if (pop_ok) begin
      rd_q <= mem[head_q];
    end
  end

  assign stat_o.empty   = empty;
  assign stat_o.count   = count_q;
  assign stat_o.rd_slot = rd_q;

endmodule

@@ tb/round_robin_task_scheduler_core_test.sv @@
// Self-checking testbench for the round-robin task scheduler core: directed and random
// requests are driven through valid/ready and each result is checked against a predictor.
// Depends on rrts_pkg and round_robin_task_scheduler_core.
module round_robin_task_scheduler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 5_000_000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 30;

  typedef struct packed {
    rrts_pkg::rrts_op_e op;
    logic [31:0]        top;
    logic [31:0]        size;
    logic [31:0]        sp;
    logic [15:0]        pid;
  } sched_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  sched_req_t drv = '0;

  logic        in_ready;
  logic        out_valid;
  logic [2:0]  status;
  logic [15:0] task_id;
  logic        is_running;
  logic [31:0] next_sp;
  logic [3:0]  next_slot;
  logic        freed_valid;
  logic [31:0] freed_base;

  sched_req_t             req_queue[$];
  rrts_pkg::rrts_result_t due_results[$];
  int send_idle = 38;
  int recv_idle = 83;
  int err_cnt = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_cnt = 0;
  int adds_queued = 0;

  // Predictor state.
  logic [15:0]           tbl_id[rrts_pkg::MaxTasks];
  bit                    tbl_run[rrts_pkg::MaxTasks];
  logic [31:0]           tbl_sp[rrts_pkg::MaxTasks];
  logic [31:0]           tbl_top[rrts_pkg::MaxTasks];
  logic [31:0]           tbl_size[rrts_pkg::MaxTasks];
  int unsigned           ready_slots[$];
  rrts_pkg::rrts_nslot_t cur_slot = '0;
  logic [15:0]           next_id = '0;

  initial begin
    for (int i = 0; i < rrts_pkg::MaxTasks; i++) begin
      tbl_id[i] = '0;
      tbl_run[i] = 1'b0;
    end
  end

  always #5 clk_i = ~clk_i;

  round_robin_task_scheduler_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .opcode_i      (drv.op),
    .stack_top_i   (drv.top),
    .stack_bytes_i (drv.size),
    .saved_sp_i    (drv.sp),
    .query_pid_i   (drv.pid),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .task_id_o     (task_id),
    .is_running_o  (is_running),
    .next_sp_o     (next_sp),
    .next_slot_o   (next_slot),
    .freed_valid_o (freed_valid),
    .freed_base_o  (freed_base)
  );

  function automatic void ready_push(int unsigned slot);
    if (ready_slots.size() < rrts_pkg::MaxTasks) ready_slots.push_back(slot);
  endfunction

  function automatic void dispatch_next(output rrts_pkg::rrts_status_e st,
                                        output logic [31:0] nsp);
    int unsigned s;
    int unsigned k;
    logic [31:0] floor_addr;
    s = 0;
    if (ready_slots.size() > 0) s = ready_slots.pop_front();
    cur_slot = rrts_pkg::rrts_nslot_t'(s);
    nsp = '0;
    st = rrts_pkg::StNoReady;
    if (s != 0) begin
      k = s - 1;
      nsp = tbl_sp[k];
      floor_addr = tbl_top[k] - tbl_size[k];
      st = (tbl_sp[k] < floor_addr) ? rrts_pkg::StOverflow : rrts_pkg::StOk;
    end
  endfunction

  function automatic rrts_pkg::rrts_result_t schedule_step(sched_req_t r);
    rrts_pkg::rrts_result_t res;
    rrts_pkg::rrts_status_e st;
    logic [31:0]            nsp;
    int unsigned            free_slot;
    int unsigned            old;
    res = '0;
    res.status = rrts_pkg::StOk;
    case (r.op)
      rrts_pkg::OpAdd: begin
        free_slot = 0;
        for (int i = rrts_pkg::MaxTasks - 1; i >= 0; i--) begin
          if (!tbl_run[i]) free_slot = i + 1;
        end
        if (free_slot == 0) begin
          res.status = rrts_pkg::StFull;
        end else begin
          old = free_slot - 1;
          tbl_id[old] = next_id;
          res.task_id = next_id;
          next_id = next_id + 16'd1;
          tbl_run[old] = 1'b1;
          tbl_top[old] = r.top;
          tbl_size[old] = r.size;
          tbl_sp[old] = r.top - 32'(rrts_pkg::FrameBytes);
          ready_push(free_slot);
        end
      end
      rrts_pkg::OpYield: begin
        if (cur_slot != 0) begin
          tbl_sp[cur_slot - 1] = r.sp;
          ready_push(cur_slot);
        end
        dispatch_next(st, nsp);
        res.status = st;
        res.next_sp = nsp;
      end
      rrts_pkg::OpExit: begin
        if (cur_slot == 0) begin
          res.status = rrts_pkg::StNoCurrent;
        end else begin
          old = cur_slot - 1;
          tbl_sp[old] = r.sp;
          dispatch_next(st, nsp);
          res.status = st;
          res.next_sp = nsp;
          res.freed_valid = 1'b1;
          res.freed_base = tbl_top[old] - tbl_size[old];
          tbl_run[old] = 1'b0;
        end
      end
      default: begin
        if (r.pid != 0) begin
          for (int i = 0; i < rrts_pkg::MaxTasks; i++) begin
            if (tbl_run[i] && tbl_id[i] == r.pid) res.is_running = 1'b1;
          end
        end
      end
    endcase
    res.next_slot = cur_slot;
    return res;
  endfunction

  function automatic sched_req_t req_of(rrts_pkg::rrts_op_e op, logic [31:0] top,
                                        logic [31:0] size, logic [31:0] sp,
                                        logic [15:0] pid);
    sched_req_t r;
    r.op = op;
    r.top = top;
    r.size = size;
    r.sp = sp;
    r.pid = pid;
    return r;
  endfunction

  function automatic sched_req_t random_req(rrts_pkg::rrts_op_e op);
    sched_req_t r;
    r = req_of(op, $urandom(), $urandom(), $urandom(), 16'($urandom()));
    if ($urandom_range(99) < 55) begin
      r.top = 32'h2000_0000 + 32'($urandom_range(0, 7)) * 32'h1000;
      r.size = 32'h800;
      r.sp = 32'h2000_0000 + 32'($urandom_range(0, 32'h8000));
    end
    if ($urandom_range(99) < 75) r.pid = 16'($urandom_range(0, adds_queued + 2));
    if ($urandom_range(99) < 8) r.op = rrts_pkg::rrts_op_e'(2'($urandom_range(3)));
    if (r.op == rrts_pkg::OpAdd) adds_queued++;
    return r;
  endfunction

  task automatic queue_random(int n);
    int k;
    int w;
    rrts_pkg::rrts_op_e op;
    k = 0;
    while (k < n) begin
      w = $urandom_range(99);
      op = (w < 30) ? rrts_pkg::OpAdd : (w < 60) ? rrts_pkg::OpYield :
           (w < 80) ? rrts_pkg::OpExit : rrts_pkg::OpQuery;
      repeat ($urandom_range(1, 5)) begin
        req_queue.push_back(random_req(op));
        k++;
      end
    end
  endtask

  task automatic wait_queue_empty();
    while (req_queue.size() != 0) @(negedge clk_i);
  endtask

  // Sender.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_results.push_back(schedule_step(drv));
      if (!in_valid || in_ready) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
          drv <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver, with one long hold-off to back the block up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    rrts_pkg::rrts_result_t exp;
    if (rst_ni && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (due_results.size() == 0) begin
        $error("result with no request outstanding");
        err_cnt = err_cnt + 1;
      end else begin
        exp = due_results.pop_front();
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          err_cnt = err_cnt + 1;
        end
        if (task_id !== exp.task_id) begin
          $error("task_id: expected %0d, got %0d", exp.task_id, task_id);
          err_cnt = err_cnt + 1;
        end
        if (is_running !== exp.is_running) begin
          $error("is_running: expected %0d, got %0d", exp.is_running, is_running);
          err_cnt = err_cnt + 1;
        end
        if (next_sp !== exp.next_sp) begin
          $error("next_sp: expected %h, got %h", exp.next_sp, next_sp);
          err_cnt = err_cnt + 1;
        end
        if (next_slot !== exp.next_slot) begin
          $error("next_slot: expected %0d, got %0d", exp.next_slot, next_slot);
          err_cnt = err_cnt + 1;
        end
        if (freed_valid !== exp.freed_valid) begin
          $error("freed_valid: expected %0d, got %0d", exp.freed_valid, freed_valid);
          err_cnt = err_cnt + 1;
        end
        if (freed_base !== exp.freed_base) begin
          $error("freed_base: expected %h, got %h", exp.freed_base, freed_base);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    req_queue.push_back(req_of(rrts_pkg::OpExit, '0, '0, 32'h1234_5678, '0));
    req_queue.push_back(req_of(rrts_pkg::OpYield, '0, '0, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpQuery, '0, '0, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpAdd, '0, '0, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpQuery, '0, '0, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpYield, '0, '0, 32'hFFFF_FFFF, 16'hFFFF));
    req_queue.push_back(req_of(rrts_pkg::OpExit, '0, '0, 32'h0000_0040, '0));
    req_queue.push_back(req_of(rrts_pkg::OpAdd, 32'h1000_0000, 32'h100, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpQuery, '0, '0, '0, 16'd1));
    req_queue.push_back(req_of(rrts_pkg::OpAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0));
    for (int i = 0; i < 6; i++) begin
      req_queue.push_back(req_of(rrts_pkg::OpAdd, 32'h3000_0000 + 32'(i) * 32'h1000,
                                 32'h800, '0, '0));
    end
    req_queue.push_back(req_of(rrts_pkg::OpAdd, 32'h4000_0000, 32'h10, '0, '0));
    req_queue.push_back(req_of(rrts_pkg::OpQuery, '0, '0, '0, 16'd9));
    // The last yield brings back a task whose saved pointer lies below its stack floor.
    repeat (9) req_queue.push_back(req_of(rrts_pkg::OpYield, '0, '0, '0, '0));
    adds_queued = 9;
    queue_random(215);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait_queue_empty();
    send_idle = 83;
    recv_idle = 38;
    queue_random(215);

    wait_queue_empty();
    send_idle = 0;
    recv_idle = 0;
    queue_random(215);
    // Empty the table, then add one task and switch to it.
    repeat (rrts_pkg::MaxTasks + 1) begin
      req_queue.push_back(random_req(rrts_pkg::OpYield));
      req_queue.push_back(random_req(rrts_pkg::OpExit));
    end
    req_queue.push_back(random_req(rrts_pkg::OpAdd));
    req_queue.push_back(random_req(rrts_pkg::OpYield));
    for (int i = 0; i < 12; i++) begin
      req_queue.push_back(req_of(rrts_pkg::OpQuery, '0, '0, '0, 16'(i)));
    end

    wait_queue_empty();
    while (in_valid || due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/rrts_pkg.sv
src/rrts_slot_ram.sv
src/rrts_ready_queue.sv
src/round_robin_task_scheduler_core.sv
tb/round_robin_task_scheduler_core_test.sv
